// File: src/usp_pkg.sv
// ----------------------------------------------------------------------------
// usp_pkg: shared types and constants
// Item types, configuration bundle, register indexes and byte codes for the
// URI session parameter extractor.
// ----------------------------------------------------------------------------
package usp_pkg;

    // URI size limits
    localparam int MAX_URI_LEN  = 4096;
    localparam int MAX_NAME_LEN = 16;
    localparam int POS_W        = $clog2(MAX_URI_LEN + 2);   // position saturates at len+1
    localparam int OFF_W        = 12;
    localparam int NLEN_W       = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX     = 3'd5;

    // Reset value of the value length cap
    localparam logic [OFF_W-1:0] MAX_VALUE_RST = 12'd32;

    // Parse phases
    localparam logic [1:0] PH_BEFORE = 2'd0;
    localparam logic [1:0] PH_INSIDE = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    // Request method codes
    localparam logic [1:0] METHOD_OTHER = 2'd3;

    // Delimiter bytes
    localparam logic [7:0] CH_SEMI     = 8'h3B;   // ';'
    localparam logic [7:0] CH_QUESTION = 8'h3F;   // '?'
    localparam logic [7:0] CH_AMP      = 8'h26;   // '&'
    localparam logic [7:0] CH_EQUAL    = 8'h3D;   // '='

    // Search modes
    localparam logic MODE_PATH  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic [7:0] uri_byte;
        logic [1:0] request_method;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] value_offset;
        logic [OFF_W-1:0] value_length;
        logic             too_long;
    } t_out_item;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] name_word_low;
        logic [CFG_DATA_W-1:0] name_word_high;
        logic [NLEN_W-1:0]     name_length;
        logic [OFF_W-1:0]      max_value_length;
        logic                  search_mode;
        logic                  prefix_match;
    } t_cfg;

endpackage

// File: src/usp_byte_parser.sv
// ----------------------------------------------------------------------------
// usp_byte_parser: per-byte URI parameter parser
// Holds the parse state for one URI, updates it for each accepted byte and
// forms the result item combinationally for the byte marked last.
// ----------------------------------------------------------------------------
module usp_byte_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  usp_pkg::t_in_item  i_item,
    input  usp_pkg::t_cfg      i_cfg,
    output usp_pkg::t_out_item o_result
);

    localparam int POS_W  = usp_pkg::POS_W;
    localparam int OFF_W  = usp_pkg::OFF_W;
    localparam int NLEN_W = usp_pkg::NLEN_W;

    // Parse state
    logic [POS_W-1:0]  r_pos,       n_pos;
    logic [1:0]        r_phase,     n_phase;
    logic [OFF_W-1:0]  r_seg,       n_seg;
    logic              r_match,     n_match;
    logic              r_qual,      n_qual;
    logic              r_cand_vld,  n_cand_vld;
    logic [OFF_W-1:0]  r_cand_off,  n_cand_off;
    logic [OFF_W-1:0]  r_cand_len,  n_cand_len;
    logic              r_method_ok, n_method_ok;

    // ASCII lower case
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    logic [NLEN_W-1:0]  nl;
    logic [POS_W-1:0]   name_skip;
    logic               too_long;
    logic [7:0]         opener;
    logic [7:0]         sep;
    logic [OFF_W-1:0]   pos12;
    logic [OFF_W-1:0]   k;
    logic [127:0]       name_all;
    logic [7:0]         name_c;
    logic [POS_W-1:0]   start_a;
    logic [POS_W-1:0]   start_f;
    logic [POS_W-1:0]   diff_a;
    logic [POS_W-1:0]   diff_f;
    logic               f_vld;
    logic [OFF_W-1:0]   f_off;
    logic [OFF_W-1:0]   f_len;
    logic [OFF_W-1:0]   len_cap;
    logic               hit;

    // Configuration derived values
    always_comb begin
        nl        = (i_cfg.name_length > NLEN_W'(usp_pkg::MAX_NAME_LEN)) ?
                    NLEN_W'(usp_pkg::MAX_NAME_LEN) : i_cfg.name_length;
        name_skip = POS_W'(nl) + (i_cfg.prefix_match ? POS_W'(1) : POS_W'(2));
        opener    = (i_cfg.search_mode == usp_pkg::MODE_QUERY) ?
                    usp_pkg::CH_QUESTION : usp_pkg::CH_SEMI;
        sep       = (i_cfg.search_mode == usp_pkg::MODE_QUERY) ?
                    usp_pkg::CH_AMP : usp_pkg::CH_SEMI;
        name_all  = {i_cfg.name_word_high, i_cfg.name_word_low};
    end

    // Byte parse: next state for this byte
    always_comb begin
        n_pos       = r_pos;
        n_phase     = r_phase;
        n_seg       = r_seg;
        n_match     = r_match;
        n_qual      = r_qual;
        n_cand_vld  = r_cand_vld;
        n_cand_off  = r_cand_off;
        n_cand_len  = r_cand_len;
        n_method_ok = r_method_ok && (i_item.request_method != usp_pkg::METHOD_OTHER);

        too_long = (r_pos >= POS_W'(usp_pkg::MAX_URI_LEN));
        pos12    = r_pos[OFF_W-1:0];
        k        = pos12 - r_seg - OFF_W'(1);
        name_c   = name_all[{k[3:0], 3'b000} +: 8];
        // close of the current segment at this byte
        start_a  = POS_W'(r_seg) + name_skip;
        diff_a   = r_pos - start_a;

        if (!too_long) begin
            n_pos = r_pos + POS_W'(1);
            case (r_phase)
                usp_pkg::PH_BEFORE: begin
                    if (i_item.uri_byte == opener) begin
                        n_phase = usp_pkg::PH_INSIDE;
                        n_seg   = pos12;
                        n_match = 1'b1;
                        n_qual  = 1'b0;
                    end
                end
                usp_pkg::PH_INSIDE: begin
                    if (i_cfg.search_mode == usp_pkg::MODE_PATH &&
                        i_item.uri_byte == usp_pkg::CH_QUESTION) begin
                        if (r_qual) begin
                            n_cand_vld = 1'b1;
                            n_cand_off = start_a[OFF_W-1:0];
                            n_cand_len = (r_pos >= start_a) ? diff_a[OFF_W-1:0] : '0;
                        end
                        n_qual  = 1'b0;
                        n_phase = usp_pkg::PH_DONE;
                    end else if (i_item.uri_byte == sep) begin
                        if (r_qual) begin
                            n_cand_vld = 1'b1;
                            n_cand_off = start_a[OFF_W-1:0];
                            n_cand_len = (r_pos >= start_a) ? diff_a[OFF_W-1:0] : '0;
                        end
                        n_seg   = pos12;
                        n_match = 1'b1;
                        n_qual  = 1'b0;
                    end else if (k < OFF_W'(nl)) begin
                        if (to_lower(i_item.uri_byte) != to_lower(name_c)) begin
                            n_match = 1'b0;
                        end
                    end else if (k == OFF_W'(nl)) begin
                        n_qual = r_match && (i_cfg.prefix_match ||
                                             i_item.uri_byte == usp_pkg::CH_EQUAL);
                    end
                end
                default: begin
                end
            endcase
        end else begin
            n_pos = POS_W'(usp_pkg::MAX_URI_LEN + 1);
        end
    end

    // End of URI: close the open segment and form the result
    always_comb begin
        start_f = POS_W'(n_seg) + name_skip;
        diff_f  = n_pos - start_f;
        f_vld   = n_cand_vld;
        f_off   = n_cand_off;
        f_len   = n_cand_len;
        if (n_phase == usp_pkg::PH_INSIDE && n_qual) begin
            f_vld = 1'b1;
            f_off = start_f[OFF_W-1:0];
            f_len = (n_pos >= start_f) ? diff_f[OFF_W-1:0] : '0;
        end
        len_cap = (f_len < i_cfg.max_value_length) ? f_len : i_cfg.max_value_length;
        hit     = !too_long && n_method_ok && (nl != '0) && f_vld && (len_cap != '0);

        o_result.found        = hit;
        o_result.value_offset = hit ? f_off : '0;
        o_result.value_length = hit ? len_cap : '0;
        o_result.too_long     = too_long;
    end

    // State registers; cleared after each last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_pos       <= '0;
            r_phase     <= usp_pkg::PH_BEFORE;
            r_seg       <= '0;
            r_match     <= 1'b0;
            r_qual      <= 1'b0;
            r_cand_vld  <= 1'b0;
            r_cand_off  <= '0;
            r_cand_len  <= '0;
            r_method_ok <= 1'b1;
        end else if (i_step) begin
            r_pos       <= n_pos;
            r_phase     <= n_phase;
            r_seg       <= n_seg;
            r_match     <= n_match;
            r_qual      <= n_qual;
            r_cand_vld  <= n_cand_vld;
            r_cand_off  <= n_cand_off;
            r_cand_len  <= n_cand_len;
            r_method_ok <= n_method_ok;
        end
    end

    // Position saturates just past the URI limit
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(usp_pkg::MAX_URI_LEN + 1))
        else $error("byte position past saturation");

    // A last byte always restarts the URI state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.last_byte |=> r_pos == '0 && r_phase == usp_pkg::PH_BEFORE
                                        && !r_cand_vld)
        else $error("URI state not cleared after last byte");

    // Once inside the parameter area, the phase never falls back mid-URI
    a_phase_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_item.last_byte && r_phase != usp_pkg::PH_BEFORE
        |=> r_phase != usp_pkg::PH_BEFORE)
        else $error("parse phase went backward");

    // A reported value is never empty, over the cap, or paired with too_long
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.found |-> !o_result.too_long && o_result.value_length != '0
                           && o_result.value_length <= i_cfg.max_value_length)
        else $error("inconsistent found result");

endmodule

// File: src/uri_session_param_extract_core.sv
// ----------------------------------------------------------------------------
// uri_session_param_extract_core: session parameter locator for request URIs
// Scans a request URI one byte per item and reports where the configured
// session parameter's value sits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one URI byte per item
//   with the request method and a last-byte mark. One result item leaves on
//   the output channel (o_out_valid / i_out_ready) for each URI, built from
//   its last byte: found flag, value offset, capped value length, too_long.
//   The result is registered and valid in the cycle after the last byte is accepted.
//   One byte per cycle while the output register is free; parse state updates
//   in a single pass between the input handshake and the result register.
//   A result waiting in the output register holds o_in_ready low until the
//   receiver takes it; with the receiver ready, a byte is taken every cycle,
//   last bytes included.
//   Configuration writes (i_cfg_valid, index, data) are always accepted and
//   must only happen while no URI is in flight.
//   Reset (synchronous, active low) clears the parse state and the result
//   valid flag and loads register defaults: empty name, cap 32, path mode.
// ----------------------------------------------------------------------------
module uri_session_param_extract_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // byte input
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  usp_pkg::t_in_item                  i_in_item,
    // result output
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output usp_pkg::t_out_item                 o_out_item,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [usp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [usp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    usp_pkg::t_cfg      r_cfg;
    usp_pkg::t_out_item r_out_item;
    usp_pkg::t_out_item result;
    logic               r_out_valid;
    logic               accept;

    // Output register frees up as it drains
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.name_word_low    <= '0;
            r_cfg.name_word_high   <= '0;
            r_cfg.name_length      <= '0;
            r_cfg.max_value_length <= usp_pkg::MAX_VALUE_RST;
            r_cfg.search_mode      <= usp_pkg::MODE_PATH;
            r_cfg.prefix_match     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                usp_pkg::CFG_NAME_LOW:  r_cfg.name_word_low    <= i_cfg_data;
                usp_pkg::CFG_NAME_HIGH: r_cfg.name_word_high   <= i_cfg_data;
                usp_pkg::CFG_NAME_LEN:  r_cfg.name_length      <=
                                            i_cfg_data[usp_pkg::NLEN_W-1:0];
                usp_pkg::CFG_MAX_VALUE: r_cfg.max_value_length <=
                                            i_cfg_data[usp_pkg::OFF_W-1:0];
                usp_pkg::CFG_MODE:      r_cfg.search_mode      <= i_cfg_data[0];
                usp_pkg::CFG_PREFIX:    r_cfg.prefix_match     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Parser
    usp_byte_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (accept),
        .i_item   (i_in_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // Result register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_in_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register: payload
    always_ff @(posedge i_clk) begin
        if (accept && i_in_item.last_byte) begin
            r_out_item <= result;
        end
    end

endmodule

// File: test/tb_uri_session_param_extract_core.sv
// ----------------------------------------------------------------------------
// tb_uri_session_param_extract_core: self-checking URI extractor bench
// Streams request URIs into the block one byte per item and predicts every
// result in the bench. It covers directed cases for path and query modes,
// prefix match, methods, caps and oversize URIs, then randomized URIs under
// changing register settings. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_uri_session_param_extract_core;

    // request method codes not named in the package
    localparam logic [1:0] METH_GET  = 2'd0;
    localparam logic [1:0] METH_POST = 2'd1;
    localparam logic [1:0] METH_HEAD = 2'd2;

    // idle cycles let pass after the last result before a register write or the end
    localparam int RESULT_LATENCY = 4;
    // cycles without any handshake: far above any sender gap, receiver stall
    // or drain pause in a correct run
    localparam int WATCHDOG_LIMIT = 2000;

    // DUT ports
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    usp_pkg::t_in_item              i_in_item   = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    usp_pkg::t_out_item             o_out_item;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [usp_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [usp_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // register copy and per-URI parse state of the predictor
    usp_pkg::t_cfg cfg_shadow;
    int unsigned   pos_cnt;
    logic [1:0]    phase;
    int unsigned   seg_start;
    bit            name_ok;
    bit            seg_hit;
    bit            cand_valid;
    int unsigned   cand_off;
    int unsigned   cand_len;
    bit            method_good;

    // expected results, oldest first
    usp_pkg::t_out_item expected_results[$];
    logic [7:0]         uri_bytes[$];

    // sender burst, receiver pattern, watchdog
    int          burst_left   = 0;
    logic [15:0] rx_pattern   = 16'hFFFF;
    logic [5:0]  rx_slot      = '0;
    int          idle_cycles  = 0;

    // run statistics
    int fail_count     = 0;
    int uris_sent      = 0;
    int bytes_sent     = 0;
    int results_seen   = 0;
    int found_seen     = 0;
    int too_long_seen  = 0;
    int settings_used  = 0;

    uri_session_param_extract_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock, period 4
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int unsigned name_len_used();
        return (cfg_shadow.name_length > usp_pkg::MAX_NAME_LEN) ? usp_pkg::MAX_NAME_LEN
                                                                : cfg_shadow.name_length;
    endfunction

    function automatic logic [7:0] fold_case(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] name_at(int unsigned k);
        if (k < 8) return cfg_shadow.name_word_low[k*8 +: 8];
        return cfg_shadow.name_word_high[(k-8)*8 +: 8];
    endfunction

    function automatic void clear_uri();
        pos_cnt     = 0;
        phase       = usp_pkg::PH_BEFORE;
        seg_start   = 0;
        name_ok     = 1'b0;
        seg_hit     = 1'b0;
        cand_valid  = 1'b0;
        cand_off    = 0;
        cand_len    = 0;
        method_good = 1'b1;
    endfunction

    function automatic void open_seg(int unsigned p);
        seg_start = p;
        name_ok   = 1'b1;
        seg_hit   = 1'b0;
    endfunction

    // end_pos is just past the segment
    function automatic void close_seg(int unsigned end_pos);
        int unsigned s;
        if (seg_hit) begin
            s = seg_start + name_len_used() + (cfg_shadow.prefix_match ? 1 : 2);
            cand_valid = 1'b1;
            cand_off   = s;
            cand_len   = (end_pos >= s) ? end_pos - s : 0;
        end
        seg_hit = 1'b0;
    endfunction

    function automatic void parse_char(logic [7:0] c, int unsigned p);
        logic [7:0]  opener;
        logic [7:0]  sep;
        int unsigned k;
        int unsigned nl;
        opener = (cfg_shadow.search_mode == usp_pkg::MODE_QUERY) ? usp_pkg::CH_QUESTION
                                                                  : usp_pkg::CH_SEMI;
        sep    = (cfg_shadow.search_mode == usp_pkg::MODE_QUERY) ? usp_pkg::CH_AMP
                                                                  : usp_pkg::CH_SEMI;
        nl     = name_len_used();
        if (phase == usp_pkg::PH_BEFORE) begin
            if (c == opener) begin
                phase = usp_pkg::PH_INSIDE;
                open_seg(p);
            end
        end else if (phase == usp_pkg::PH_INSIDE) begin
            if (cfg_shadow.search_mode == usp_pkg::MODE_PATH && c == usp_pkg::CH_QUESTION) begin
                close_seg(p);
                phase = usp_pkg::PH_DONE;
            end else if (c == sep) begin
                close_seg(p);
                open_seg(p);
            end else begin
                k = p - seg_start - 1;
                if (k < nl) begin
                    if (fold_case(c) != fold_case(name_at(k))) name_ok = 1'b0;
                end else if (k == nl) begin
                    seg_hit = name_ok && (cfg_shadow.prefix_match || c == usp_pkg::CH_EQUAL);
                end
            end
        end
    endfunction

    // one accepted byte; the last byte of a URI queues its result
    function automatic void advance_uri(usp_pkg::t_in_item it);
        bit                 over;
        int unsigned        len;
        usp_pkg::t_out_item r;
        if (it.request_method == usp_pkg::METHOD_OTHER) method_good = 1'b0;
        if (pos_cnt < usp_pkg::MAX_URI_LEN) begin
            parse_char(it.uri_byte, pos_cnt);
            pos_cnt++;
            over = 1'b0;
        end else begin
            pos_cnt = usp_pkg::MAX_URI_LEN + 1;
            over    = 1'b1;
        end
        if (it.last_byte) begin
            if (phase == usp_pkg::PH_INSIDE) close_seg(pos_cnt);
            r = '0;
            if (!over && method_good && name_len_used() != 0 && cand_valid) begin
                len = (cand_len < cfg_shadow.max_value_length) ? cand_len
                                                               : cfg_shadow.max_value_length;
                if (len > 0) begin
                    r.found        = 1'b1;
                    r.value_offset = cand_off[usp_pkg::OFF_W-1:0];
                    r.value_length = len[usp_pkg::OFF_W-1:0];
                end
            end
            r.too_long = over;
            expected_results.push_back(r);
            clear_uri();
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        usp_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result item with none expected: found %0b off %0d len %0d long %0b",
                       o_out_item.found, o_out_item.value_offset,
                       o_out_item.value_length, o_out_item.too_long);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                results_seen++;
                if (want.found) found_seen++;
                if (want.too_long) too_long_seen++;
                if (o_out_item.found !== want.found) begin
                    $error("found: expected %0b, actual %0b", want.found, o_out_item.found);
                    fail_count++;
                end
                if (o_out_item.value_offset !== want.value_offset) begin
                    $error("value_offset: expected %0d, actual %0d",
                           want.value_offset, o_out_item.value_offset);
                    fail_count++;
                end
                if (o_out_item.value_length !== want.value_length) begin
                    $error("value_length: expected %0d, actual %0d",
                           want.value_length, o_out_item.value_length);
                    fail_count++;
                end
                if (o_out_item.too_long !== want.too_long) begin
                    $error("too_long: expected %0b, actual %0b",
                           want.too_long, o_out_item.too_long);
                    fail_count++;
                end
            end
        end
    end

    // receiver: a random 16-bit ready pattern, replayed and drawn anew each time the slot counter wraps
    always @(negedge i_clk) begin
        if (rx_slot == 0) begin
            case ($urandom_range(0, 3))
                0:       rx_pattern = 16'hFFFF;
                1:       rx_pattern = 16'($urandom);
                2:       rx_pattern = 16'($urandom & $urandom);
                default: rx_pattern = 16'($urandom | $urandom);
            endcase
            if (rx_pattern == 16'h0) rx_pattern = 16'h0001;
        end
        i_out_ready = rx_pattern[rx_slot[3:0]];
        rx_slot     = rx_slot + 6'd1;
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results pending",
                         idle_cycles, expected_results.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving tasks (entered and left at a falling edge)
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic [1:0] meth, input logic lst);
        usp_pkg::t_in_item it;
        int                gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 10);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        it.uri_byte       = b;
        it.request_method = meth;
        it.last_byte      = lst;
        i_in_item  = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        advance_uri(it);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // hold the sender until every result is in, then let the block settle
    task automatic wait_results();
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (RESULT_LATENCY) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [usp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [usp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            usp_pkg::CFG_NAME_LOW:  cfg_shadow.name_word_low    = data;
            usp_pkg::CFG_NAME_HIGH: cfg_shadow.name_word_high   = data;
            usp_pkg::CFG_NAME_LEN:  cfg_shadow.name_length      = data[usp_pkg::NLEN_W-1:0];
            usp_pkg::CFG_MAX_VALUE: cfg_shadow.max_value_length = data[usp_pkg::OFF_W-1:0];
            usp_pkg::CFG_MODE:      cfg_shadow.search_mode      = data[0];
            usp_pkg::CFG_PREFIX:    cfg_shadow.prefix_match     = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // all six registers; unused upper bits carry junk
    task automatic load_settings(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [4:0] nlen, input logic [11:0] cap,
                                 input logic mode, input logic pre);
        logic [63:0] junk;
        wait_results();
        junk = {$urandom, $urandom};
        write_reg(usp_pkg::CFG_NAME_LOW, lo);
        write_reg(usp_pkg::CFG_NAME_HIGH, hi);
        write_reg(usp_pkg::CFG_NAME_LEN, {junk[63:5], nlen});
        write_reg(usp_pkg::CFG_MAX_VALUE, {junk[63:12], cap});
        write_reg(usp_pkg::CFG_MODE, {junk[63:1], mode});
        write_reg(usp_pkg::CFG_PREFIX, {junk[62:0], pre});
        settings_used++;
    endtask

    task automatic set_named(input string nm, input logic [4:0] nlen, input logic mode,
                             input logic pre, input logic [11:0] cap);
        logic [127:0] packed_name;
        packed_name = '0;
        for (int k = 0; k < nm.len() && k < 16; k++) packed_name[k*8 +: 8] = nm[k];
        load_settings(packed_name[63:0], packed_name[127:64], nlen, cap, mode, pre);
    endtask

    // send uri_bytes; other_at marks one byte with an unsupported method,
    // pause_at holds the sender until all results are in
    task automatic send_uri(input logic [1:0] meth, input int other_at, input int pause_at);
        int n;
        n = uri_bytes.size();
        for (int i = 0; i < n; i++) begin
            if (i == pause_at) wait_results();
            send_byte(uri_bytes[i], (i == other_at) ? usp_pkg::METHOD_OTHER : meth, i == n - 1);
        end
        uris_sent++;
    endtask

    // ------------------------------------------------------------------
    // URI builders
    // ------------------------------------------------------------------
    function automatic void add_str(string s);
        for (int k = 0; k < s.len(); k++) uri_bytes.push_back(s[k]);
    endfunction

    function automatic void load_str(string s);
        uri_bytes.delete();
        add_str(s);
    endfunction

    function automatic void add_repeat(logic [7:0] b, int n);
        repeat (n) uri_bytes.push_back(b);
    endfunction

    function automatic void add_plain(int n);
        string alph = "abcxyzABCXYZ0189-._~%/";
        repeat (n) uri_bytes.push_back(alph[$urandom_range(0, alph.len() - 1)]);
    endfunction

    function automatic logic [7:0] rand_name_byte();
        string alph = "abcdefsidSIDXYZ0123_-";
        if ($urandom_range(0, 4) == 0) return 8'($urandom);
        return alph[$urandom_range(0, alph.len() - 1)];
    endfunction

    // configured name with random case; miss spoils one byte
    function automatic void add_name(bit miss);
        int unsigned n;
        int unsigned bad;
        logic [7:0]  b;
        n   = name_len_used();
        bad = (n == 0) ? 0 : $urandom_range(0, n - 1);
        for (int unsigned k = 0; k < n; k++) begin
            b = name_at(k);
            if (fold_case(b) >= "a" && fold_case(b) <= "z" && $urandom_range(0, 1))
                b = b ^ 8'h20;
            if (miss && k == bad) b = b ^ 8'h01;
            uri_bytes.push_back(b);
        end
    endfunction

    function automatic void add_segment();
        int kind;
        int vlen;
        kind = $urandom_range(0, 9);
        vlen = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 50) : $urandom_range(0, 6);
        if (kind <= 4) begin
            add_name(1'b0);
            if (!cfg_shadow.prefix_match || $urandom_range(0, 1))
                uri_bytes.push_back(usp_pkg::CH_EQUAL);
            add_plain(vlen);
        end else if (kind == 5) begin
            add_name(1'b0);
        end else if (kind == 6) begin
            add_name(1'b1);
            uri_bytes.push_back(usp_pkg::CH_EQUAL);
            add_plain(vlen);
        end else if (kind == 7) begin
            add_plain($urandom_range(1, 6));
        end else if (kind == 9) begin
            add_name(1'b0);
            uri_bytes.push_back(usp_pkg::CH_EQUAL);
        end
        // kind 8: empty segment
    endfunction

    // mostly well-formed URIs around the configured name, some pure noise
    function automatic void build_random_uri();
        logic [7:0] opener;
        logic [7:0] sep;
        int         nseg;
        uri_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 24)) uri_bytes.push_back(8'($urandom));
            return;
        end
        opener = (cfg_shadow.search_mode == usp_pkg::MODE_QUERY) ? usp_pkg::CH_QUESTION
                                                                  : usp_pkg::CH_SEMI;
        sep    = (cfg_shadow.search_mode == usp_pkg::MODE_QUERY) ? usp_pkg::CH_AMP
                                                                  : usp_pkg::CH_SEMI;
        uri_bytes.push_back("/");
        add_plain($urandom_range(0, 5));
        // path parameters are not searched in query mode
        if (cfg_shadow.search_mode == usp_pkg::MODE_QUERY && $urandom_range(0, 3) == 0) begin
            uri_bytes.push_back(usp_pkg::CH_SEMI);
            add_segment();
        end
        if ($urandom_range(0, 9) != 0) begin
            uri_bytes.push_back(opener);
            nseg = $urandom_range(1, 4);
            for (int s = 0; s < nseg; s++) begin
                if (s > 0) uri_bytes.push_back(sep);
                add_segment();
            end
            // query after path parameters ends the search
            if (cfg_shadow.search_mode == usp_pkg::MODE_PATH && $urandom_range(0, 2) == 0) begin
                uri_bytes.push_back(usp_pkg::CH_QUESTION);
                add_segment();
                uri_bytes.push_back(usp_pkg::CH_SEMI);
                add_segment();
            end
        end
    endfunction

    task automatic randomize_settings();
        logic [127:0] nm;
        logic [4:0]   nlen;
        logic [11:0]  cap;
        int           r;
        for (int k = 0; k < 16; k++) nm[k*8 +: 8] = rand_name_byte();
        r = $urandom_range(0, 9);
        nlen = (r == 0) ? 5'd0 : (r == 1) ? 5'($urandom_range(17, 31)) :
               (r == 2) ? 5'd16 : 5'($urandom_range(1, 8));
        r = $urandom_range(0, 9);
        cap  = (r == 0) ? 12'd0 : (r == 1) ? 12'd4095 :
               (r == 2) ? 12'd1 : 12'($urandom_range(2, 40));
        load_settings(nm[63:0], nm[127:64], nlen, cap, 1'($urandom), 1'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // register defaults: empty name finds nothing
    task automatic test_reset_defaults();
        load_str("/a;b=c");
        send_uri(METH_GET, -1, -1);
    endtask

    task automatic test_path_params();
        set_named("sid", 5'd3, usp_pkg::MODE_PATH, 1'b0, 12'd32);
        load_str("/a;SiD=ab;x=1?sid=q");
        send_uri(METH_GET, -1, -1);
        // name with nothing after it
        load_str("/;x=1;sid");
        send_uri(METH_POST, -1, -1);
        // last match has an empty value
        load_str("/;sid=1;sid=");
        send_uri(METH_HEAD, -1, -1);
        // later near match keeps the earlier candidate
        load_str("/;sid=7;sidq=2");
        send_uri(METH_GET, -1, -1);
        // '?' before the first ';' does not end the search
        load_str("/?x;sid=zz");
        send_uri(METH_GET, -1, -1);
    endtask

    task automatic test_query_prefix();
        set_named("sid", 5'd3, usp_pkg::MODE_QUERY, 1'b0, 12'd32);
        load_str("/p;sid=no?a=b&SID=xyz&c");
        send_uri(METH_GET, -1, -1);
        load_str("?sid=abc&sid=d");
        send_uri(METH_POST, -1, -1);
        set_named("sid", 5'd3, usp_pkg::MODE_QUERY, 1'b1, 12'd32);
        load_str("?a&sidABC&x");
        send_uri(METH_GET, -1, -1);
        load_str("?sid");
        send_uri(METH_HEAD, -1, -1);
    endtask

    task automatic test_methods();
        set_named("k", 5'd1, usp_pkg::MODE_PATH, 1'b0, 12'd32);
        load_str("/;k=v");
        send_uri(usp_pkg::METHOD_OTHER, -1, -1);
        // one byte of an unsupported method spoils the URI
        load_str("/;k=v");
        send_uri(METH_GET, 2, -1);
        load_str("/;k=v");
        send_uri(METH_HEAD, -1, -1);
    endtask

    task automatic test_limits();
        // cap zero
        set_named("sid", 5'd3, usp_pkg::MODE_PATH, 1'b0, 12'd0);
        load_str("/;sid=abc");
        send_uri(METH_GET, -1, -1);
        // cap one
        set_named("sid", 5'd3, usp_pkg::MODE_PATH, 1'b0, 12'd1);
        load_str("/;sid=abc");
        send_uri(METH_POST, -1, -1);
        // oversized name length saturates at the full 16 bytes
        set_named("ABCDEFGHIJKLMNOP", 5'd31, usp_pkg::MODE_PATH, 1'b1, 12'd4095);
        load_str("/;abcdefghijklmnopQ=1");
        send_uri(METH_GET, -1, -1);
        // name length zero disables the search
        set_named("", 5'd0, usp_pkg::MODE_QUERY, 1'b0, 12'd4095);
        load_str("?=x");
        send_uri(METH_GET, -1, -1);
    endtask

    task automatic test_long_uris();
        set_named("sid", 5'd3, usp_pkg::MODE_PATH, 1'b0, 12'd4095);
        // exactly the maximum length, value running to the end
        load_str("/;sid=");
        add_repeat("v", 4090);
        send_uri(METH_GET, -1, 2000);
        // one byte over
        load_str("/;sid=");
        add_repeat("v", 4091);
        send_uri(METH_POST, -1, -1);
        // match at the far end of a full-length URI
        uri_bytes.delete();
        add_repeat("x", 4089);
        add_str(";sid=ab");
        send_uri(METH_HEAD, -1, -1);
        // state must be clean again
        load_str("/;sid=ok");
        send_uri(METH_GET, -1, -1);
    endtask

    task automatic test_random();
        int         rnd_bytes;
        int         rnd_uris;
        int         r;
        int         other_at;
        int         pause_at;
        logic [1:0] meth;
        rnd_bytes = 0;
        rnd_uris  = 0;
        while (rnd_bytes < 800 || rnd_uris < 40) begin
            if (rnd_uris % 6 == 0) randomize_settings();
            build_random_uri();
            r        = $urandom_range(0, 9);
            meth     = (r < 8) ? 2'($urandom_range(0, 2)) :
                       (r == 8) ? usp_pkg::METHOD_OTHER : METH_GET;
            other_at = (r == 9) ? $urandom_range(0, uri_bytes.size() - 1) : -1;
            pause_at = (rnd_uris == 0 || $urandom_range(0, 15) == 0)
                       ? $urandom_range(0, uri_bytes.size() - 1) : -1;
            rnd_bytes += uri_bytes.size();
            send_uri(meth, other_at, pause_at);
            rnd_uris++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        cfg_shadow                  = '0;
        cfg_shadow.max_value_length = usp_pkg::MAX_VALUE_RST;
        cfg_shadow.search_mode      = usp_pkg::MODE_PATH;
        clear_uri();
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_path_params();
        test_query_prefix();
        test_methods();
        test_limits();
        test_long_uris();
        test_random();

        wait_results();
        $display("Ran %0d URIs (%0d bytes) under %0d register settings.",
                 uris_sent, bytes_sent, settings_used);
        $display("Checked %0d results: %0d with a value found, %0d over length.",
                 results_seen, found_seen, too_long_seen);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
